### rtl/accel_stillness_detector_macros.svh
// Assertion macros for the checker file of the stillness detector, asd_check.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef ACCEL_STILLNESS_DETECTOR_MACROS_SVH
`define ACCEL_STILLNESS_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/asd_pkg.sv
// Shared types, register codes and constants of the accelerometer stillness detector.
// Used by the top level, asd_convert and asd_window; depends on nothing else.
package asd_pkg;

	localparam int SampleW    = 16;
	localparam int MgW        = 12;
	localparam int MagMgW     = 11;
	localparam int LimitW     = 11;
	localparam int TimeW      = 32;
	localparam int CfgIndexW  = 3;
	localparam int CfgDataW   = 32;
	localparam int CmpW       = 14;

	// floor(mag * 61 / 1000) equals (mag * MgRecip) >> MgRecipShift for every
	// 16-bit magnitude: the rounding error stays below one part in a thousand.
	localparam int            MgRecipShift = 25;
	localparam int            MgRecipW     = 21;
	localparam int            MgProdW      = SampleW + MgRecipW;
	localparam logic [MgRecipW-1:0] MgRecip = 21'd2046821;

	typedef enum logic [CfgIndexW-1:0] {
		REG_X_LIMIT        = 3'd0,
		REG_Y_LIMIT        = 3'd1,
		REG_Z_CENTER       = 3'd2,
		REG_Z_TOLERANCE    = 3'd3,
		REG_QUIET_DURATION = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LimitW-1:0]     x_limit;
		logic [LimitW-1:0]     y_limit;
		logic signed [MgW-1:0] z_center;
		logic [LimitW-1:0]     z_tolerance;
		logic [TimeW-1:0]      quiet_duration_ms;
	} cfg_t;

	localparam logic [LimitW-1:0]     XLimitReset   = 11'd150;
	localparam logic [LimitW-1:0]     YLimitReset   = 11'd150;
	localparam logic signed [MgW-1:0] ZCenterReset  = -12'sd1000;
	localparam logic [LimitW-1:0]     ZTolReset     = 11'd200;
	localparam logic [TimeW-1:0]      QuietDurReset = 32'd20000;

endpackage

### rtl/accel_stillness_detector.sv
// Top level of the accelerometer stillness detector: input register, conversion,
// window check and result register. Depends on asd_pkg, asd_convert and asd_window.
//
// Usage: each request on the slave stream carries one three-axis sample in raw
// counts and the current millisecond time. For every request exactly one result
// leaves on the master stream: the three axes in milli-g, a still flag and a
// quiet flag that rises once stillness has lasted the programmed duration.
// A request is registered at acceptance; its result then passes through the converters
// and the window check into the output register, where m_tvalid rises.
// Throughput is one request per cycle while m_tready is high, set by the single pass through the
// constant-multiply converters and the window compare between the two registers.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more request; s_tready falls only when both
// are full, and rises in the same cycle that m_tready frees the output.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Reset clears both valid flags and the stillness start time and loads the
// default limits; no request is lost across a stall.
module accel_stillness_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata, from bit 0: x_sample[15:0], y_sample[15:0], z_sample[15:0], now_ms[31:0]
	input  logic [79:0]                      s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata, from bit 0: x_mg[11:0], y_mg[11:0], z_mg[11:0], four zero bits
	output logic [39:0]                      m_tdata,
	// m_tuser, from bit 0: is_still, quiet_event
	output logic [1:0]                       m_tuser,
	input  logic                             cfg_we,
	input  logic [asd_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [asd_pkg::CfgDataW-1:0]     cfg_wdata
);
	import asd_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic [79:0]            data_s1;
	logic                   valid_s2;
	logic signed [MgW-1:0]  x_mg_s2, y_mg_s2, z_mg_s2;
	logic                   still_s2, quiet_s2;
	logic signed [MgW-1:0]  x_mg, y_mg, z_mg;
	logic                   is_still, quiet_event;
	logic                   advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_limit           <= XLimitReset;
			cfg_q.y_limit           <= YLimitReset;
			cfg_q.z_center          <= ZCenterReset;
			cfg_q.z_tolerance       <= ZTolReset;
			cfg_q.quiet_duration_ms <= QuietDurReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_LIMIT:        cfg_q.x_limit           <= cfg_wdata[LimitW-1:0];
				REG_Y_LIMIT:        cfg_q.y_limit           <= cfg_wdata[LimitW-1:0];
				REG_Z_CENTER:       cfg_q.z_center          <= $signed(cfg_wdata[MgW-1:0]);
				REG_Z_TOLERANCE:    cfg_q.z_tolerance       <= cfg_wdata[LimitW-1:0];
				REG_QUIET_DURATION: cfg_q.quiet_duration_ms <= cfg_wdata[TimeW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
		if (advance) begin
			x_mg_s2  <= x_mg;
			y_mg_s2  <= y_mg;
			z_mg_s2  <= z_mg;
			still_s2 <= is_still;
			quiet_s2 <= quiet_event;
		end
	end

	asd_convert u_conv_x (.raw($signed(data_s1[15:0])),  .mg(x_mg));
	asd_convert u_conv_y (.raw($signed(data_s1[31:16])), .mg(y_mg));
	asd_convert u_conv_z (.raw($signed(data_s1[47:32])), .mg(z_mg));

	asd_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.cfg         (cfg_q),
		.x_mg        (x_mg),
		.y_mg        (y_mg),
		.z_mg        (z_mg),
		.now_ms      (data_s1[79:48]),
		.is_still    (is_still),
		.quiet_event (quiet_event)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, z_mg_s2, y_mg_s2, x_mg_s2};
	assign m_tuser  = {quiet_s2, still_s2};

endmodule

### rtl/asd_convert.sv
// One axis of raw-count to milli-g conversion, truncating toward zero.
// Uses the reciprocal constants of asd_pkg.
module asd_convert (
	input  logic signed [asd_pkg::SampleW-1:0] raw,
	output logic signed [asd_pkg::MgW-1:0]     mg
);
	import asd_pkg::*;

	logic [SampleW-1:0] raw_u;
	logic [SampleW-1:0] mag;
	logic [MgProdW-1:0] prod;
	logic [MagMgW-1:0]  mag_mg;
	logic [MgW-1:0]     mg_ext;

	assign raw_u = raw;
	// The most negative count still fits as an unsigned 16-bit magnitude.
	assign mag   = raw_u[SampleW-1] ? (~raw_u + SampleW'(1)) : raw_u;
	assign prod  = MgProdW'(mag) * MgProdW'(MgRecip);
	assign mag_mg = prod[MgRecipShift +: MagMgW];
	assign mg_ext = {1'b0, mag_mg};
	assign mg    = raw_u[SampleW-1] ? (~mg_ext + MgW'(1)) : mg_ext;

endmodule

### rtl/asd_window.sv
// Still-window comparison and the stillness start-time tracker.
// Uses the configuration struct from asd_pkg.
module asd_window (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  asd_pkg::cfg_t                    cfg,
	input  logic signed [asd_pkg::MgW-1:0]   x_mg,
	input  logic signed [asd_pkg::MgW-1:0]   y_mg,
	input  logic signed [asd_pkg::MgW-1:0]   z_mg,
	input  logic [asd_pkg::TimeW-1:0]        now_ms,
	output logic                             is_still,
	output logic                             quiet_event
);
	import asd_pkg::*;

	logic signed [CmpW-1:0] x_w, y_w, z_w;
	logic signed [CmpW-1:0] xl_w, yl_w, zt_w, zc_w, z_hi, z_lo;
	logic [TimeW-1:0]       elapsed;
	logic [TimeW-1:0]       still_since_q;
	logic                   since_valid_q;

	assign x_w  = $signed({{(CmpW-MgW){x_mg[MgW-1]}}, x_mg});
	assign y_w  = $signed({{(CmpW-MgW){y_mg[MgW-1]}}, y_mg});
	assign z_w  = $signed({{(CmpW-MgW){z_mg[MgW-1]}}, z_mg});
	assign xl_w = $signed({{(CmpW-LimitW){1'b0}}, cfg.x_limit});
	assign yl_w = $signed({{(CmpW-LimitW){1'b0}}, cfg.y_limit});
	assign zt_w = $signed({{(CmpW-LimitW){1'b0}}, cfg.z_tolerance});
	assign zc_w = $signed({{(CmpW-MgW){cfg.z_center[MgW-1]}}, cfg.z_center});
	assign z_hi = zc_w + zt_w;
	assign z_lo = zc_w - zt_w;

	assign is_still = (x_w < xl_w) && (x_w > -xl_w) &&
	                  (y_w < yl_w) && (y_w > -yl_w) &&
	                  (z_w < z_hi) && (z_w > z_lo);

	// The first still sample of a run starts the clock, so its elapsed time is zero.
	assign elapsed     = since_valid_q ? (now_ms - still_since_q) : '0;
	assign quiet_event = is_still && (elapsed >= cfg.quiet_duration_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_since_q <= '0;
			since_valid_q <= 1'b0;
		end else if (advance) begin
			if (is_still) begin
				if (!since_valid_q) begin
					still_since_q <= now_ms;
					since_valid_q <= 1'b1;
				end
			end else begin
				still_since_q <= '0;
				since_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/asd_check.sv
// Port-level checks of the stillness detector, bound to its top level.
// Depends on accel_stillness_detector_macros.svh.
`include "accel_stillness_detector_macros.svh"

module asd_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic signed [11:0] x_mg_w, y_mg_w, z_mg_w;
	logic               mg_ok;

	assign x_mg_w = m_tdata[11:0];
	assign y_mg_w = m_tdata[23:12];
	assign z_mg_w = m_tdata[35:24];
	assign mg_ok  = (x_mg_w <= 12'sd1998) && (x_mg_w >= -12'sd1998) &&
	                (y_mg_w <= 12'sd1998) && (y_mg_w >= -12'sd1998) &&
	                (z_mg_w <= 12'sd1998) && (z_mg_w >= -12'sd1998);

	// A quiet result can only come from a still sample.
	`ASD_ASSERT_NOW(a_quiet_needs_still, m_tvalid, !m_tuser[1] || m_tuser[0], "quiet without still")

	// The converted axes never leave the milli-g range of a 16-bit count.
	`ASD_ASSERT_NOW(a_mg_range, m_tvalid, mg_ok, "milli-g out of range")

	// Back-pressure on the input only ever comes from a stalled, full output.
	`ASD_ASSERT_NOW(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

	// A stalled result stays in place.
	`ASD_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind accel_stillness_detector asd_check u_asd_check (.*);

### bench/accel_stillness_detector_tb.sv
// Self-checking bench for accel_stillness_detector: directed corner samples, then random phases
// of still runs, boundary samples and noise under random settings and random stream stalls.
// Depends on asd_pkg and the RTL top level; the scoreboard class below predicts every result.
module accel_stillness_detector_tb;
	import asd_pkg::*;

	localparam int SDataW = 80;
	localparam int MDataW = 40;
	localparam int MgMax  = 1998;
	localparam int ReportMax = 10;
	localparam int ItemTarget = 2000;
	// Highest index of the three-bit register index; no register lives there.
	localparam logic [CfgIndexW-1:0] RegSpareTop = '1;

	typedef struct packed {
		logic signed [SampleW-1:0] x;
		logic signed [SampleW-1:0] y;
		logic signed [SampleW-1:0] z;
		logic [TimeW-1:0]          now;
	} sample_t;

	typedef struct packed {
		logic signed [MgW-1:0] x_mg;
		logic signed [MgW-1:0] y_mg;
		logic signed [MgW-1:0] z_mg;
		logic                  still;
		logic                  quiet;
	} verdict_t;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_RUNS,
		READY_MOSTLY
	} ready_mode_t;

	class stillness_scoreboard;
		cfg_t             regs;
		logic [TimeW-1:0] still_since;
		bit               since_valid;
		verdict_t         expected_q[$];
		int               errors;

		function new();
			regs.x_limit           = XLimitReset;
			regs.y_limit           = YLimitReset;
			regs.z_center          = ZCenterReset;
			regs.z_tolerance       = ZTolReset;
			regs.quiet_duration_ms = QuietDurReset;
			still_since = '0;
			since_valid = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_X_LIMIT:        regs.x_limit = data[LimitW-1:0];
				REG_Y_LIMIT:        regs.y_limit = data[LimitW-1:0];
				REG_Z_CENTER:       regs.z_center = data[MgW-1:0];
				REG_Z_TOLERANCE:    regs.z_tolerance = data[LimitW-1:0];
				REG_QUIET_DURATION: regs.quiet_duration_ms = data[TimeW-1:0];
				default: ;
			endcase
		endfunction

		// Truncation toward zero of |raw| * 61 / 1000, sign restored afterwards.
		static function logic signed [MgW-1:0] to_milli_g(logic signed [SampleW-1:0] raw);
			int s;
			int mag;
			int m;
			s   = raw;
			mag = (s < 0) ? -s : s;
			m   = (mag * 61) / 1000;
			return MgW'((s < 0) ? -m : m);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_sample(sample_t smp);
			verdict_t         v;
			int               xm, ym, zm, xl, yl, zc, zt;
			logic [TimeW-1:0] elapsed;
			xm = to_milli_g(smp.x);
			ym = to_milli_g(smp.y);
			zm = to_milli_g(smp.z);
			xl = regs.x_limit;
			yl = regs.y_limit;
			zc = $signed(regs.z_center);
			zt = regs.z_tolerance;
			v.x_mg  = MgW'(xm);
			v.y_mg  = MgW'(ym);
			v.z_mg  = MgW'(zm);
			v.still = (xm < xl) && (xm > -xl) && (ym < yl) && (ym > -yl) &&
				(zm < zc + zt) && (zm > zc - zt);
			v.quiet = 1'b0;
			if (v.still) begin
				if (!since_valid) begin
					still_since = smp.now;
					since_valid = 1'b1;
				end
				elapsed = smp.now - still_since;
				v.quiet = (elapsed >= regs.quiet_duration_ms);
			end else begin
				still_since = '0;
				since_valid = 1'b0;
			end
			expected_q.push_back(v);
		endfunction

		function void check_result(logic [MDataW-1:0] tdata, logic [1:0] tuser);
			verdict_t exp_v;
			verdict_t got;
			got.x_mg  = tdata[MgW-1:0];
			got.y_mg  = tdata[2*MgW-1:MgW];
			got.z_mg  = tdata[3*MgW-1:2*MgW];
			got.still = tuser[0];
			got.quiet = tuser[1];
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= ReportMax)
					$display("unexpected result: x=%0d y=%0d z=%0d still=%0b quiet=%0b",
						got.x_mg, got.y_mg, got.z_mg, got.still, got.quiet);
				return;
			end
			exp_v = expected_q.pop_front();
			if (got !== exp_v) begin
				errors++;
				if (errors <= ReportMax) begin
					$display("result differs: expected x=%0d y=%0d z=%0d still=%0b quiet=%0b",
						exp_v.x_mg, exp_v.y_mg, exp_v.z_mg, exp_v.still, exp_v.quiet);
					$display("                got      x=%0d y=%0d z=%0d still=%0b quiet=%0b",
						got.x_mg, got.y_mg, got.z_mg, got.still, got.quiet);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SDataW-1:0]     s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [MDataW-1:0]     m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CfgIndexW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0]   cfg_wdata = '0;

	stillness_scoreboard sb = new();
	ready_mode_t         ready_mode = READY_ALWAYS;
	int                  gap_max = 0;
	int                  burst_left = 0;
	int                  hold_left = 0;
	bit                  ready_phase = 1'b0;
	logic [TimeW-1:0]    tick_ms = '0;

	accel_stillness_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
			READY_RUNS: begin
				if (hold_left == 0) begin
					ready_phase = !ready_phase;
					hold_left = ready_phase ? $urandom_range(1, 8) : $urandom_range(1, 12);
				end
				hold_left--;
				m_tready <= ready_phase;
			end
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic send_sample(input sample_t smp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 99) == 0) begin
				wait_drained();
			end else begin
				gap = $urandom_range(0, gap_max);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {smp.now, smp.z, smp.y, smp.x};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(smp);
	endtask

	// A raw count whose conversion lands on mg; the jitter stays inside the same milli-g step.
	function automatic logic signed [SampleW-1:0] raw_for_mg(int mg);
		int mag;
		int raw;
		if (mg > MgMax)
			mg = MgMax;
		if (mg < -MgMax)
			mg = -MgMax;
		mag = (mg < 0) ? -mg : mg;
		raw = (mag * 1000 + 60) / 61 + $urandom_range(0, 8);
		if (raw > 32767)
			raw = 32767;
		return SampleW'((mg < 0) ? -raw : raw);
	endfunction

	function automatic sample_t mk(int xm, int ym, int zm, logic [TimeW-1:0] now);
		sample_t s;
		s.x   = raw_for_mg(xm);
		s.y   = raw_for_mg(ym);
		s.z   = raw_for_mg(zm);
		s.now = now;
		return s;
	endfunction

	function automatic sample_t raw_sample(int x, int y, int z, logic [TimeW-1:0] now);
		sample_t s;
		s.x   = SampleW'(x);
		s.y   = SampleW'(y);
		s.z   = SampleW'(z);
		s.now = now;
		return s;
	endfunction

	// When the window is empty after clipping to the converter range, any value will do.
	function automatic int pick_between(int lo, int hi);
		if (lo < -MgMax)
			lo = -MgMax;
		if (hi > MgMax)
			hi = MgMax;
		if (lo > hi)
			return int'($urandom_range(0, 2 * MgMax)) - MgMax;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic logic [LimitW-1:0] rand_limit();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return LimitW'($urandom_range(1, 2000));
	endfunction

	task automatic program_random_setting();
		logic [CfgDataW-1:0] w;
		int                  roll;
		int                  zc;
		w = $urandom;
		w[LimitW-1:0] = rand_limit();
		write_reg(REG_X_LIMIT, w);
		w = $urandom;
		w[LimitW-1:0] = rand_limit();
		write_reg(REG_Y_LIMIT, w);
		w = $urandom;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			w[MgW-1:0] = {1'b1, {(MgW-1){1'b0}}};
		else if (roll == 1)
			w[MgW-1:0] = {1'b0, {(MgW-1){1'b1}}};
		else begin
			zc = int'($urandom_range(0, 4000)) - 2000;
			w[MgW-1:0] = zc[MgW-1:0];
		end
		write_reg(REG_Z_CENTER, w);
		w = $urandom;
		w[LimitW-1:0] = rand_limit();
		write_reg(REG_Z_TOLERANCE, w);
		roll = $urandom_range(0, 19);
		if (roll < 2)
			w = '0;
		else if (roll == 2)
			w = '1;
		else if (roll == 3)
			w = $urandom;
		else
			w = $urandom_range(1, 300);
		write_reg(REG_QUIET_DURATION, w);
		if ($urandom_range(0, 2) == 0)
			write_reg(CfgIndexW'($urandom_range(int'(RegSpareTop),
				int'(REG_QUIET_DURATION) + 1)), $urandom);
		cfg_we <= 1'b0;
		if ($urandom_range(0, 3) == 0)
			tick_ms = '1 - $urandom_range(0, 200);
	endtask

	// Mostly still runs with random content; some samples sit on a window edge, some are noise.
	task automatic run_phase(input int count);
		sample_t smp;
		int      xm, ym, zm, xl, yl, zc, zt, step_max, pick, sgn;
		xl = sb.regs.x_limit;
		yl = sb.regs.y_limit;
		zc = $signed(sb.regs.z_center);
		zt = sb.regs.z_tolerance;
		step_max = (sb.regs.quiet_duration_ms <= 400) ?
			int'(sb.regs.quiet_duration_ms) / 8 + 2 : 40;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				tick_ms = $urandom;
			else
				tick_ms += $urandom_range(0, step_max);
			if (pick < 10) begin
				smp.x   = SampleW'($urandom);
				smp.y   = SampleW'($urandom);
				smp.z   = SampleW'($urandom);
				smp.now = $urandom_range(0, 1) ? tick_ms : $urandom;
				send_sample(smp);
				continue;
			end
			xm = pick_between(1 - xl, xl - 1);
			ym = pick_between(1 - yl, yl - 1);
			zm = pick_between(zc - zt + 1, zc + zt - 1);
			if (pick < 22) begin
				sgn = $urandom_range(0, 1) ? 1 : -1;
				case ($urandom_range(0, 2))
					0: xm = sgn * (xl - int'($urandom_range(0, 1)));
					1: ym = sgn * (yl - int'($urandom_range(0, 1)));
					default: zm = zc + sgn * (zt - int'($urandom_range(0, 1)));
				endcase
			end
			send_sample(mk(xm, ym, zm, tick_ms));
		end
	endtask

	initial begin
		int count;
		int sent_total;
		sent_total = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: raw extremes, a full quiet run and samples on and just inside the window edges.
		gap_max = 2;
		ready_mode = READY_COIN;
		send_sample(raw_sample(-32768, 32767, 0, '0));
		send_sample(raw_sample(32767, -32768, -32768, '1));
		send_sample(mk(0, 0, -1000, 100));
		send_sample(mk(149, -149, -1199, 100 + 19999));
		send_sample(mk(-149, 149, -801, 100 + 20000));
		send_sample(mk(150, 0, -1000, 100 + 20001));
		send_sample(mk(0, -150, -1000, 100 + 20002));
		send_sample(mk(0, 0, -1200, 100 + 20003));
		send_sample(mk(0, 0, -800, 100 + 20004));
		send_sample(mk(-150, 0, -1000, 100 + 20005));
		wait_drained();

		// A zero duration fires on the very first still sample.
		write_reg(REG_QUIET_DURATION, '0);
		cfg_we <= 1'b0;
		send_sample(mk(0, 0, -1000, 500));
		send_sample(mk(0, 0, -1000, 501));
		wait_drained();

		// Elapsed time across the wrap of the millisecond counter.
		write_reg(REG_QUIET_DURATION, 32'h20);
		cfg_we <= 1'b0;
		send_sample(mk(MgMax, 0, -1000, 32'hFFFF_FFE0));
		send_sample(mk(0, 0, -1000, 32'hFFFF_FFF0));
		send_sample(mk(0, 0, -1000, 32'h0000_000F));
		send_sample(mk(0, 0, -1000, 32'h0000_0010));
		wait_drained();

		// A zero x limit admits nothing; the spare index must leave the settings alone.
		write_reg(REG_X_LIMIT, '0);
		write_reg(RegSpareTop, '1);
		cfg_we <= 1'b0;
		send_sample(mk(0, 0, -1000, 32'h0000_0011));
		wait_drained();

		// Widest window with the longest duration, then a window that cannot hold any sample.
		write_reg(REG_X_LIMIT, '1);
		write_reg(REG_Y_LIMIT, '1);
		write_reg(REG_Z_CENTER, {{(CfgDataW-MgW){1'b0}}, 1'b1, {(MgW-1){1'b0}}});
		write_reg(REG_Z_TOLERANCE, '1);
		write_reg(REG_QUIET_DURATION, '1);
		cfg_we <= 1'b0;
		send_sample(raw_sample(32767, -32768, -32768, 32'h1234_5678));
		send_sample(raw_sample(-32768, 32767, -32768, 32'h1234_5676));
		wait_drained();
		write_reg(REG_Z_CENTER, {{(CfgDataW-MgW){1'b0}}, 1'b0, {(MgW-1){1'b1}}});
		write_reg(REG_Z_TOLERANCE, '0);
		cfg_we <= 1'b0;
		send_sample(mk(0, 0, MgMax, 32'h1234_5679));
		wait_drained();

		while (sent_total < ItemTarget) begin
			count = $urandom_range(60, 220);
			program_random_setting();
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			run_phase(count);
			wait_drained();
			sent_total += count;
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
